// File: design/mbup_pkg.sv
// Package for the serial MIDI to USB-MIDI packetizer.
// Holds the MIDI byte codes, USB-MIDI code index values and the packet type.
// No dependencies.
package mbup_pkg;

    // Serial MIDI byte codes.
    localparam logic [7:0] MIDI_SYSEX_START   = 8'hF0;
    localparam logic [7:0] MIDI_SYSEX_END     = 8'hF7;
    localparam logic [7:0] MIDI_REALTIME_MIN  = 8'hF8;
    localparam logic [7:0] MIDI_STATUS_MIN    = 8'h80;
    localparam logic [3:0] MIDI_PROG_CHANGE   = 4'hC;
    localparam logic [3:0] MIDI_CHAN_PRESSURE = 4'hD;

    // USB-MIDI code index numbers.
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CIN_REALTIME   = 4'hF;

    // Message byte counts.
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // One USB-MIDI event packet, cable zero.
    typedef struct packed {
        logic [3:0] code_index;
        logic [1:0] msg_length;
        logic [7:0] midi_first;
        logic [7:0] midi_second;
        logic [7:0] midi_third;
    } t_packet;

endpackage

// File: design/midi_byte_to_usb_midi_packetizer.sv
// Top level of the serial MIDI to USB-MIDI event packetizer.
// Input register, message assembler and output register. Depends on mbup_pkg, mbup_assembler.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-----------------------------------------
//   input   | in        | i_valid / o_ready  | i_midi_byte
//   output  | out       | o_valid / i_ready  | o_code_index, o_msg_length, o_midi_first,
//           |           |                    | o_midi_second, o_midi_third
//
// One byte is accepted per cycle while o_ready is high; any packet it completes is registered.
// The input register and the output register form a two-stage pipeline, so one transfer
// per cycle is sustained on both sides while the consumer keeps i_ready high.
// A stalled output holds its packet and stops the input register; o_ready then follows it.
// Synchronous active-low reset empties both registers and clears the message buffer.
module midi_byte_to_usb_midi_packetizer
    import mbup_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_midi_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_code_index,
    output logic [1:0] o_msg_length,
    output logic [7:0] o_midi_first,
    output logic [7:0] o_midi_second,
    output logic [7:0] o_midi_third
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_packet    r_out_pkt;
    logic       w_step;
    logic       w_emit;
    t_packet    w_packet;

    // The held byte is processed when the output slot is free or being emptied.
    assign w_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_midi_byte;
        end
    end

    mbup_assembler u_assembler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .o_emit   (w_emit),
        .o_packet (w_packet)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_pkt <= w_packet;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_code_index  = r_out_pkt.code_index;
    assign o_msg_length  = r_out_pkt.msg_length;
    assign o_midi_first  = r_out_pkt.midi_first;
    assign o_midi_second = r_out_pkt.midi_second;
    assign o_midi_third  = r_out_pkt.midi_third;

    // Every packet carries at least one byte.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_msg_length != LEN_NONE)
        else $error("packet with zero length");

    // A real-time packet is a single byte with the unused bytes cleared.
    a_realtime_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_midi_first >= MIDI_REALTIME_MIN) |->
        (o_code_index == CIN_REALTIME && o_msg_length == LEN_ONE &&
         o_midi_second == 8'h00 && o_midi_third == 8'h00))
        else $error("malformed real-time packet");

    // A byte held in the input register is not lost or overwritten while stalled.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte changed");

endmodule

// File: design/mbup_assembler.sv
// Message assembler: collects MIDI bytes in a three-byte buffer and builds packets.
// Depends on mbup_pkg.
module mbup_assembler
    import mbup_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output t_packet    o_packet
);

    logic [7:0] r_buf [3];
    logic [7:0] n_buf [3];
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    logic [1:0] r_expected;
    logic [1:0] n_expected;
    logic       r_in_sysex;
    logic       n_in_sysex;

    // Working copy of the buffer after the incoming byte is stored.
    logic [7:0] v_buf [3];
    logic [1:0] v_fill;

    // Next state and packet for one byte.
    always_comb begin
        n_buf      = r_buf;
        n_fill     = r_fill;
        n_expected = r_expected;
        n_in_sysex = r_in_sysex;
        v_buf      = r_buf;
        v_fill     = r_fill;
        o_emit     = 1'b0;
        o_packet   = '{code_index: CIN_REALTIME, msg_length: LEN_ONE,
                       midi_first: i_byte, midi_second: 8'h00, midi_third: 8'h00};

        if (i_byte inside {[MIDI_REALTIME_MIN:8'hFF]}) begin
            // Real-time bytes pass straight through and leave the buffer alone.
            o_emit = 1'b1;
        end else if (r_in_sysex) begin
            // A full buffer starts over before the byte goes in.
            if (v_fill == LEN_THREE) begin
                v_buf      = '{8'h00, 8'h00, 8'h00};
                v_fill     = LEN_NONE;
                n_expected = LEN_NONE;
            end
            if (v_fill != LEN_THREE) begin
                v_buf[v_fill] = i_byte;
                v_fill        = v_fill + LEN_ONE;
            end
            o_packet.msg_length  = v_fill;
            o_packet.midi_first  = v_buf[0];
            o_packet.midi_second = v_buf[1];
            o_packet.midi_third  = v_buf[2];
            if (i_byte == MIDI_SYSEX_END) begin
                // End of SysEx: code index 5, 6 or 7 by the chunk length.
                n_in_sysex          = 1'b0;
                o_emit              = 1'b1;
                o_packet.code_index = CIN_SYSEX_CONT + {2'b00, v_fill};
            end else if (v_fill == LEN_THREE) begin
                o_emit              = 1'b1;
                o_packet.code_index = CIN_SYSEX_CONT;
            end
            if (o_emit) begin
                n_buf      = '{8'h00, 8'h00, 8'h00};
                n_fill     = LEN_NONE;
                n_expected = LEN_NONE;
            end else begin
                n_buf  = v_buf;
                n_fill = v_fill;
            end
        end else if (i_byte >= MIDI_STATUS_MIN) begin
            // A new status opens a message; 0xF0 also enters SysEx mode.
            n_buf  = '{i_byte, 8'h00, 8'h00};
            n_fill = LEN_ONE;
            if (i_byte == MIDI_SYSEX_START) begin
                n_in_sysex = 1'b1;
                n_expected = LEN_THREE;
            end else if (i_byte[7:4] inside {MIDI_PROG_CHANGE, MIDI_CHAN_PRESSURE}) begin
                n_expected = LEN_TWO;
            end else begin
                n_expected = LEN_THREE;
            end
        end else if (r_expected != LEN_NONE) begin
            // Data byte for a pending status; data with none pending is dropped.
            if (v_fill != LEN_THREE) begin
                v_buf[v_fill] = i_byte;
                v_fill        = v_fill + LEN_ONE;
            end
            o_packet.msg_length  = v_fill;
            o_packet.midi_first  = v_buf[0];
            o_packet.midi_second = v_buf[1];
            o_packet.midi_third  = v_buf[2];
            o_packet.code_index  = (v_buf[0] == MIDI_SYSEX_END) ? CIN_SYSEX_END1
                                                                 : v_buf[0][7:4];
            if (v_fill >= r_expected) begin
                o_emit     = 1'b1;
                n_buf      = '{8'h00, 8'h00, 8'h00};
                n_fill     = LEN_NONE;
                n_expected = LEN_NONE;
            end else begin
                n_buf  = v_buf;
                n_fill = v_fill;
            end
        end
    end

    // Buffer and mode registers advance only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf      <= '{8'h00, 8'h00, 8'h00};
            r_fill     <= LEN_NONE;
            r_expected <= LEN_NONE;
            r_in_sysex <= 1'b0;
        end else if (i_step) begin
            r_buf      <= n_buf;
            r_fill     <= n_fill;
            r_expected <= n_expected;
            r_in_sysex <= n_in_sysex;
        end
    end

endmodule

// File: sim/tb_top.sv
// Testbench for the serial MIDI to USB-MIDI event packetizer.
// Drives MIDI byte streams, predicts every event packet and checks each output transfer.
// Depends on mbup_pkg and midi_byte_to_usb_midi_packetizer.
module tb_top;
    import mbup_pkg::*;

    // MIDI status bytes used by the directed sequences.
    localparam logic [7:0] NOTE_OFF       = 8'h80;
    localparam logic [7:0] NOTE_ON        = 8'h90;
    localparam logic [7:0] POLY_PRESSURE  = 8'hA0;
    localparam logic [7:0] PROG_CHANGE_5  = {MIDI_PROG_CHANGE, 4'h5};
    localparam logic [7:0] CHAN_PRESS_0   = {MIDI_CHAN_PRESSURE, 4'h0};
    localparam logic [7:0] SONG_POSITION  = 8'hF2;
    localparam logic [7:0] SYSTEM_RESET   = 8'hFF;
    localparam logic [7:0] TIMING_CLOCK   = 8'hF8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_midi_byte = 8'h00;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [3:0] o_code_index;
    logic [1:0] o_msg_length;
    logic [7:0] o_midi_first;
    logic [7:0] o_midi_second;
    logic [7:0] o_midi_third;

    // Message assembler mirror used to predict packets.
    logic [7:0] asm_buf [3];
    logic [1:0] asm_fill = LEN_NONE;
    logic [1:0] asm_need = LEN_NONE;
    logic       asm_sysex = 1'b0;

    t_packet     pending_packets[$];
    int unsigned bytes_sent = 0;
    int unsigned fail_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned stall_left = 0;
    int unsigned sink_gap;

    midi_byte_to_usb_midi_packetizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_midi_byte   (i_midi_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_index  (o_code_index),
        .o_msg_length  (o_msg_length),
        .o_midi_first  (o_midi_first),
        .o_midi_second (o_midi_second),
        .o_midi_third  (o_midi_third)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 7) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    task automatic clear_message();
        asm_buf[0] = 8'h00;
        asm_buf[1] = 8'h00;
        asm_buf[2] = 8'h00;
        asm_fill = LEN_NONE;
        asm_need = LEN_NONE;
    endtask

    task automatic start_message(input logic [7:0] status, input logic [1:0] need);
        asm_buf[0] = status;
        asm_buf[1] = 8'h00;
        asm_buf[2] = 8'h00;
        asm_fill = LEN_ONE;
        asm_need = need;
    endtask

    task automatic queue_packet(input logic [3:0] cin);
        t_packet pkt;
        pkt.code_index  = cin;
        pkt.msg_length  = asm_fill;
        pkt.midi_first  = asm_buf[0];
        pkt.midi_second = asm_buf[1];
        pkt.midi_third  = asm_buf[2];
        pending_packets.push_back(pkt);
        clear_message();
    endtask

    // Advance the assembler by one byte and queue the packet it completes, if any.
    task automatic packetize_byte(input logic [7:0] value);
        t_packet pkt;
        if (value >= MIDI_REALTIME_MIN) begin
            // Real-time bytes bypass the buffer entirely.
            pkt.code_index  = CIN_REALTIME;
            pkt.msg_length  = LEN_ONE;
            pkt.midi_first  = value;
            pkt.midi_second = 8'h00;
            pkt.midi_third  = 8'h00;
            pending_packets.push_back(pkt);
        end else if (asm_sysex) begin
            // Everything but the end marker is SysEx payload.
            if (asm_fill == LEN_THREE) clear_message();
            asm_buf[asm_fill] = value;
            asm_fill = asm_fill + 2'd1;
            if (value == MIDI_SYSEX_END) begin
                asm_sysex = 1'b0;
                queue_packet(CIN_SYSEX_CONT + 4'(asm_fill));
            end else if (asm_fill == LEN_THREE) begin
                queue_packet(CIN_SYSEX_CONT);
            end
        end else if (value == MIDI_SYSEX_START) begin
            asm_sysex = 1'b1;
            start_message(value, LEN_THREE);
        end else if (value >= MIDI_STATUS_MIN) begin
            if (value[7:4] == MIDI_PROG_CHANGE || value[7:4] == MIDI_CHAN_PRESSURE) begin
                start_message(value, LEN_TWO);
            end else begin
                start_message(value, LEN_THREE);
            end
        end else if (asm_need != LEN_NONE) begin
            // Data byte for a pending status; no running status afterwards.
            if (asm_fill != LEN_THREE) begin
                asm_buf[asm_fill] = value;
                asm_fill = asm_fill + 2'd1;
            end
            if (asm_fill >= asm_need) begin
                if (asm_buf[0] == MIDI_SYSEX_END) queue_packet(CIN_SYSEX_END1);
                else queue_packet(asm_buf[0][7:4]);
            end
        end
    endtask

    // Send one byte after a random gap and wait for its transfer.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = pick_gap(idle_pct);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_midi_byte <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        packetize_byte(value);
        bytes_sent++;
    endtask

    // Occasionally slip a real-time byte in ahead of the given byte.
    task automatic send_with_realtime(input logic [7:0] value);
        if ($urandom_range(0, 19) == 0) begin
            send_byte(MIDI_REALTIME_MIN + 8'($urandom_range(0, 7)));
        end
        send_byte(value);
    endtask

    // Mostly well-formed messages with random content, plus broken ones and noise.
    task automatic send_random_stream(input int unsigned count);
        int unsigned target;
        int unsigned kind;
        int unsigned n;
        logic [7:0]  value;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // Channel voice message, sometimes cut short.
                value = NOTE_OFF + 8'($urandom_range(0, 111));
                n = (value[7:4] == MIDI_PROG_CHANGE || value[7:4] == MIDI_CHAN_PRESSURE) ? 1 : 2;
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n - 1);
                send_with_realtime(value);
                repeat (n) send_with_realtime(8'($urandom_range(0, 127)));
            end else if (kind < 65) begin
                // SysEx, mostly short, sometimes long or left open.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
                send_with_realtime(MIDI_SYSEX_START);
                repeat (n) begin
                    if ($urandom_range(0, 7) == 0) value = NOTE_OFF + 8'($urandom_range(0, 8'h76));
                    else value = 8'($urandom_range(0, 127));
                    send_with_realtime(value);
                end
                if ($urandom_range(0, 9) != 0) send_with_realtime(MIDI_SYSEX_END);
            end else if (kind < 75) begin
                // System common status with two data bytes.
                send_with_realtime(8'hF1 + 8'($urandom_range(0, 6)));
                repeat (2) send_with_realtime(8'($urandom_range(0, 127)));
            end else if (kind < 85) begin
                send_byte(MIDI_REALTIME_MIN + 8'($urandom_range(0, 7)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Extremes and each special case of the message assembler.
    task automatic test_directed();
        logic [7:0] seq[$];
        idle_pct = 20;
        stall_pct = 20;
        seq = '{SYSTEM_RESET, 8'h00,
                NOTE_ON, 8'h3C, 8'h7F, 8'h7F,
                PROG_CHANGE_5, 8'h00,
                CHAN_PRESS_0, 8'h7F,
                MIDI_SYSEX_START, 8'h01, TIMING_CLOCK, 8'h02, MIDI_SYSEX_END,
                MIDI_SYSEX_START, MIDI_SYSEX_END,
                MIDI_SYSEX_START, NOTE_ON, MIDI_SYSEX_END,
                SONG_POSITION, 8'h01, 8'h02,
                MIDI_SYSEX_END, 8'h00, 8'h00,
                NOTE_OFF, POLY_PRESSURE, 8'h7F, 8'h00};
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    task automatic test_full_rate();
        idle_pct = 0;
        stall_pct = 0;
        send_random_stream(300);
    endtask

    task automatic test_random_gaps();
        idle_pct = 30;
        stall_pct = 30;
        send_random_stream(350);
    endtask

    task automatic test_backpressure();
        idle_pct = 10;
        stall_pct = 70;
        send_random_stream(200);
    endtask

    // Output side stalls at random.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            sink_gap = pick_gap(stall_pct);
            if (sink_gap != 0) begin
                stall_left <= sink_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Compare each output transfer with the oldest predicted packet.
    always @(posedge i_clk) begin
        t_packet want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_packets.size() == 0) begin
                $error("unexpected packet: code_index %0h first %02h", o_code_index, o_midi_first);
                fail_count++;
            end else begin
                want = pending_packets.pop_front();
                if (o_code_index !== want.code_index) begin
                    $error("code_index expected %0h got %0h", want.code_index, o_code_index);
                    fail_count++;
                end
                if (o_msg_length !== want.msg_length) begin
                    $error("msg_length expected %0d got %0d", want.msg_length, o_msg_length);
                    fail_count++;
                end
                if (o_midi_first !== want.midi_first) begin
                    $error("midi_first expected %02h got %02h", want.midi_first, o_midi_first);
                    fail_count++;
                end
                if (o_midi_second !== want.midi_second) begin
                    $error("midi_second expected %02h got %02h", want.midi_second, o_midi_second);
                    fail_count++;
                end
                if (o_midi_third !== want.midi_third) begin
                    $error("midi_third expected %02h got %02h", want.midi_third, o_midi_third);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        clear_message();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_rate();
        test_random_gaps();
        test_backpressure();
        i_valid <= 1'b0;
        while (pending_packets.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("midi_byte_to_usb_midi_packetizer verification clean");
        end else begin
            $display("midi_byte_to_usb_midi_packetizer verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("midi_byte_to_usb_midi_packetizer verification failed");
        $finish;
    end

endmodule

// File: midi_byte_to_usb_midi_packetizer.f
design/mbup_pkg.sv
design/mbup_assembler.sv
design/midi_byte_to_usb_midi_packetizer.sv
sim/tb_top.sv
